// ===== hdl/pavs_pkg.sv =====
// shared constants for the pen axes singular value block
package pavs_pkg;

    // configuration register
    localparam int unsigned PEN_W = 16;
    localparam logic [PEN_W-1:0] PEN_RESET = 16'd256;

    // result format
    localparam int unsigned AXIS_W = 24;
    localparam logic [AXIS_W-1:0] AXIS_MAX = {AXIS_W{1'b1}};

    // fixed point scaling: sqrt(S * 2^23) and (s * pen) >> 20
    localparam int unsigned SQRT_PRESHIFT = 23;
    localparam int unsigned PEN_SHIFT = 20;

    // radicand limit for the eigenvalue spread
    localparam int unsigned RAD_MAX_W = 128;

endpackage

// ===== hdl/pavs_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module pavs_isqrt #(
    parameter int unsigned XW = 66,
    parameter int unsigned SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_vld,
    input  logic [XW-1:0]             x,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_vld,
    output logic [(XW+(XW%2))/2-1:0]  root,
    output logic [SIDE_W-1:0]         side_out
);

    localparam int unsigned XE = XW + (XW % 2);
    localparam int unsigned RW = XE / 2;

    logic [RW:0]        rem_reg  [0:RW-1];
    logic [RW-1:0]      root_reg [0:RW-1];
    logic [XE-1:0]      x_reg    [0:RW-1];
    logic [SIDE_W-1:0]  side_reg [0:RW-1];
    logic               vld_reg  [0:RW-1];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic [RW:0]       rem_in;
        logic [RW-1:0]     root_in;
        logic [XE-1:0]     x_in;
        logic [SIDE_W-1:0] side_i;
        logic              vld_in;
        logic [RW+2:0]     cur;
        logic [RW+2:0]     trial;
        logic [RW:0]       rem_next;
        logic [RW-1:0]     root_next;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = XE'(x);
            assign side_i  = side_in;
            assign vld_in  = in_vld;
        end else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign x_in    = x_reg[g-1];
            assign side_i  = side_reg[g-1];
            assign vld_in  = vld_reg[g-1];
        end

        // trial subtract of the next bit pair
        always_comb
        begin
            cur   = {rem_in, x_in[XE-1 -: 2]};
            trial = {1'b0, root_in, 2'b01};
            if (cur >= trial)
            begin
                rem_next  = (RW+1)'(cur - trial);
                root_next = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur[RW:0];
                root_next = {root_in[RW-2:0], 1'b0};
            end
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (adv)
                vld_reg[g] <= vld_in;
        end

        // stage data
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                x_reg[g]    <= {x_in[XE-3:0], 2'b00};
                side_reg[g] <= side_i;
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign root     = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

// ===== hdl/pen_axes_singular_values_top.sv =====
// pen axes top level: singular values of a 2x2 transform scaled by pen width
//
// Input channel: four signed coefficients of the linear transform (xx, xy,
// yx, yy), taken as a transaction when in_valid is high and in_stall is low.
// Output channel: major_axis and minor_axis, unsigned Q12.12, offered with
// out_valid and held until a cycle in which out_stall is low.
// Configuration: cfg_wr_en writes cfg_wr_data into the pen width (Q8.8),
// which is 1.0 after reset; write it only while no transaction is in flight.
// Throughput: one transaction per cycle unless out_stall freezes the
// pipeline. The datapath is a single pipeline: six arithmetic stages, a
// pipelined square root of 2*COEF_WIDTH+1 stages for the eigenvalue
// spread (COEF_WIDTH up to 31), one add stage, a pair of square roots
// of COEF_WIDTH+13 stages, a pen width multiply and an output register.
// When out_stall holds a valid result the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the pen width returns to 256.
module pen_axes_singular_values_top #(
    parameter int unsigned COEF_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pavs_pkg::PEN_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COEF_WIDTH-1:0]  coef_xx,
    input  logic signed [COEF_WIDTH-1:0]  coef_xy,
    input  logic signed [COEF_WIDTH-1:0]  coef_yx,
    input  logic signed [COEF_WIDTH-1:0]  coef_yy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pavs_pkg::AXIS_W-1:0]   major_axis,
    output logic [pavs_pkg::AXIS_W-1:0]   minor_axis
);

    import pavs_pkg::*;

    localparam int unsigned W      = COEF_WIDTH;
    localparam int unsigned PW     = 2 * W;
    localparam int unsigned QW     = 4 * W;
    localparam int unsigned RAD_W  = QW + 1;
    localparam int unsigned RADS_W = (RAD_W > RAD_MAX_W) ? RAD_MAX_W : RAD_W;
    localparam int unsigned DW     = (RADS_W + (RADS_W % 2)) / 2;
    localparam int unsigned SUM_W  = PW + 1;
    localparam int unsigned SW     = ((SUM_W > DW) ? SUM_W : DW) + 1;
    localparam int unsigned XW2    = SW + SQRT_PRESHIFT;
    localparam int unsigned SGW    = (XW2 + (XW2 % 2)) / 2;
    localparam int unsigned PRW    = SGW + PEN_W;

    logic adv;

    logic [PEN_W-1:0] pen_reg;

    logic [W-1:0]  mxx_next, mxy_next, myx_next, myy_next;
    logic          same_next;
    logic [W-1:0]  mxx_reg, mxy_reg, myx_reg, myy_reg;
    logic          same1_reg, v1_reg;

    logic [PW-1:0] sxx_reg, syx_reg, sxy_reg, syy_reg, p1_reg, p2_reg;
    logic          same2_reg, v2_reg;

    logic [PW-1:0] a_reg, b_reg, k3_reg;
    logic          v3_reg;

    logic [PW-1:0]    diff_reg, k4_reg;
    logic [SUM_W-1:0] sum4_reg;
    logic             v4_reg;

    logic [QW-1:0]    dsq_reg, ksq_reg;
    logic [SUM_W-1:0] sum5_reg;
    logic             v5_reg;

    logic [RAD_W-1:0]  rad_full;
    logic [RADS_W-1:0] rad_next;
    logic [RADS_W-1:0] rad_reg;
    logic [SUM_W-1:0]  sum6_reg;
    logic              v6_reg;

    logic             vd;
    logic [DW-1:0]    d_root;
    logic [SUM_W-1:0] d_sum;

    logic [SW-1:0] sp_reg, sm_reg;
    logic          v7_reg;

    logic           vs_maj, vs_min;
    logic [SGW-1:0] sig_maj, sig_min;
    logic           side_min;

    logic [PRW-1:0] prod_maj_reg, prod_min_reg;
    logic           v8_reg;

    logic [PRW-PEN_SHIFT-1:0] q_maj, q_min;

    logic [AXIS_W-1:0] major_reg, minor_reg;
    logic              out_valid_reg;

    // pipeline moves unless a held result is stalled
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // pen width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pen_reg <= PEN_RESET;
        else if (cfg_wr_en)
            pen_reg <= cfg_wr_data;
    end

    // magnitudes and sign relation of the cross terms
    always_comb
    begin
        mxx_next  = coef_xx[W-1] ? W'(-coef_xx) : coef_xx;
        mxy_next  = coef_xy[W-1] ? W'(-coef_xy) : coef_xy;
        myx_next  = coef_yx[W-1] ? W'(-coef_yx) : coef_yx;
        myy_next  = coef_yy[W-1] ? W'(-coef_yy) : coef_yy;
        same_next = ((coef_xx[W-1] ^ coef_xy[W-1]) == (coef_yx[W-1] ^ coef_yy[W-1]));
    end

    // valid chain of the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= vd;
            v8_reg        <= vs_maj;
            out_valid_reg <= v8_reg;
        end
    end

    // radicand of the spread, saturated at the widest size
    always_comb
    begin
        rad_full = {1'b0, dsq_reg} + {ksq_reg[QW-2:0], 2'b00};
        if (RAD_W > RAD_MAX_W && (rad_full >> RAD_MAX_W) != '0)
            rad_next = '1;
        else
            rad_next = RADS_W'(rad_full);
    end

    // final scaling results
    assign q_maj = prod_maj_reg[PRW-1:PEN_SHIFT];
    assign q_min = prod_min_reg[PRW-1:PEN_SHIFT];

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: magnitudes
            mxx_reg   <= mxx_next;
            mxy_reg   <= mxy_next;
            myx_reg   <= myx_next;
            myy_reg   <= myy_next;
            same1_reg <= same_next;

            // stage 2: products
            sxx_reg   <= PW'(mxx_reg * mxx_reg);
            syx_reg   <= PW'(myx_reg * myx_reg);
            sxy_reg   <= PW'(mxy_reg * mxy_reg);
            syy_reg   <= PW'(myy_reg * myy_reg);
            p1_reg    <= PW'(mxx_reg * mxy_reg);
            p2_reg    <= PW'(myx_reg * myy_reg);
            same2_reg <= same1_reg;

            // stage 3: entries of the normal matrix
            a_reg <= sxx_reg + syx_reg;
            b_reg <= sxy_reg + syy_reg;
            if (same2_reg)
                k3_reg <= p1_reg + p2_reg;
            else if (p1_reg > p2_reg)
                k3_reg <= p1_reg - p2_reg;
            else
                k3_reg <= p2_reg - p1_reg;

            // stage 4: difference and trace
            diff_reg <= (a_reg > b_reg) ? a_reg - b_reg : b_reg - a_reg;
            k4_reg   <= k3_reg;
            sum4_reg <= {1'b0, a_reg} + {1'b0, b_reg};

            // stage 5: squares
            dsq_reg  <= QW'(diff_reg * diff_reg);
            ksq_reg  <= QW'(k4_reg * k4_reg);
            sum5_reg <= sum4_reg;

            // stage 6: radicand
            rad_reg  <= rad_next;
            sum6_reg <= sum5_reg;

            // stage 7: twice the eigenvalues, minor clamped at zero
            sp_reg <= SW'(d_sum) + SW'(d_root);
            sm_reg <= (SW'(d_sum) >= SW'(d_root)) ? SW'(d_sum) - SW'(d_root) : '0;

            // stage 8: pen width scaling
            prod_maj_reg <= PRW'(sig_maj) * PRW'(pen_reg);
            prod_min_reg <= PRW'(sig_min) * PRW'(pen_reg);

            // output register with saturation
            major_reg <= (q_maj > PRW'(AXIS_MAX)) ? AXIS_MAX : AXIS_W'(q_maj);
            minor_reg <= (q_min > PRW'(AXIS_MAX)) ? AXIS_MAX : AXIS_W'(q_min);
        end
    end

    // square root of the spread radicand
    pavs_isqrt #(
        .XW     (RADS_W),
        .SIDE_W (SUM_W)
    ) u_sqrt_spread (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (v6_reg),
        .x        (rad_reg),
        .side_in  (sum6_reg),
        .out_vld  (vd),
        .root     (d_root),
        .side_out (d_sum)
    );

    // singular value roots
    pavs_isqrt #(
        .XW     (XW2),
        .SIDE_W (1)
    ) u_sqrt_major (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (v7_reg),
        .x        ({sp_reg, {SQRT_PRESHIFT{1'b0}}}),
        .side_in  (1'b0),
        .out_vld  (vs_maj),
        .root     (sig_maj),
        .side_out ()
    );

    pavs_isqrt #(
        .XW     (XW2),
        .SIDE_W (1)
    ) u_sqrt_minor (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (v7_reg),
        .x        ({sm_reg, {SQRT_PRESHIFT{1'b0}}}),
        .side_in  (v7_reg),
        .out_vld  (vs_min),
        .root     (sig_min),
        .side_out (side_min)
    );

    assign out_valid  = out_valid_reg & (vs_min | ~vs_min | side_min | ~side_min);
    assign major_axis = major_reg;
    assign minor_axis = minor_reg;

endmodule
